// File: sv/svt_pkg.sv
// ----------------------------------------------------------------------------
// svt_pkg
// Shared request/response types and codes for the sorted value table.
// ----------------------------------------------------------------------------
package svt_pkg;

   // operation codes carried by a request
   typedef enum logic [1:0] {
      MODE_INSERT   = 2'd0,
      MODE_REMOVE   = 2'd1,
      MODE_CONTAINS = 2'd2,
      MODE_CLEAR    = 2'd3
   } mode_type;

   // completion codes carried by a response
   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_BAD_POS = 2'd2
   } status_type;

   typedef struct packed {
      mode_type           mode;
      logic signed [31:0] value;
      logic [3:0]         position;
   } svt_req_type;

   typedef struct packed {
      status_type         status;
      logic               found;
      logic signed [31:0] removed_value;
      logic [4:0]         entry_count;
      logic               is_empty;
      logic signed [31:0] min_value;
      logic signed [31:0] max_value;
   } svt_rsp_type;

endpackage

// File: sv/svt_ram.sv
// ----------------------------------------------------------------------------
// svt_ram
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module svt_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: sv/sorted_value_table_top.sv
// ----------------------------------------------------------------------------
// sorted_value_table_top
// Table of signed values kept in ascending order in a single-port-pair RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. It carries an
// operation: insert a value at its sorted place (after equal entries),
// remove the entry at a position, look a value up, or clear the table.
// Every request yields exactly one response on rsp_data, marked by a
// one-cycle rsp_valid strobe; the receiver cannot stall, so the response
// is simply dropped onto the port when ready.
// After acceptance a dispatch step picks the path: clear and a refused
// insert or remove go straight to the finish; an insert shifts larger
// entries up one place; a remove shifts the entries above its position
// down; a lookup reads every valid entry. The walk through the RAM moves
// one entry per cycle over its single read and single write port, and the
// final two reads fetch the smallest and largest entries when the table
// is not empty. busy drops in the cycle the response is shown, so a new
// request can be taken right then.
// Reset clears the count and the controller; the RAM contents are not
// cleared, entries above the count are never read.
// ----------------------------------------------------------------------------
module sorted_value_table_top
   import svt_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  svt_req_type req_data,
   output logic        rsp_valid,
   output svt_rsp_type rsp_data
);

   localparam int AW       = $clog2(CAPACITY);
   localparam int CW       = $clog2(CAPACITY + 1);
   localparam int CmpW     = (CW > 4) ? CW : 4;
   localparam int CopyBits = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int CntBits  = (CW < 5) ? CW : 5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_RM_SHIFT,
      ST_CT_SCAN,
      ST_FIN,
      ST_FIN_MIN,
      ST_FIN_MAX
   } state_type;

   state_type              state_ff, state_in;
   mode_type               mode_ff, mode_in;
   logic [VALUE_BITS-1:0]  val_ff, val_in;
   logic [3:0]             pos_ff, pos_in;
   logic [CW-1:0]          occ_ff, occ_in;
   logic [AW-1:0]          cursor_ff, cursor_in;
   logic                   first_ff, first_in;
   status_type             status_ff, status_in;
   logic                   found_ff, found_in;
   logic [VALUE_BITS-1:0]  removed_ff, removed_in;
   logic [VALUE_BITS-1:0]  min_ff, min_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   svt_rsp_type            rsp_data_ff, rsp_data_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [VALUE_BITS-1:0]  wr_data;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [VALUE_BITS-1:0]  rd_data;

   logic [VALUE_BITS-1:0]  req_val;
   logic [31:0]            min_out, max_out, rem_out;
   logic [4:0]             cnt_out;
   logic                   accept;

   svt_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (VALUE_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // request value into storage width, zero filled above bit 31
   always_comb begin
      req_val = '0;
      for (int i = 0; i < CopyBits; i++) begin
         req_val[i] = req_data.value[i];
      end
   end

   // storage values and count into response widths
   always_comb begin
      min_out = '0;
      max_out = '0;
      rem_out = '0;
      cnt_out = '0;
      for (int i = 0; i < CopyBits; i++) begin
         min_out[i] = min_ff[i];
         max_out[i] = rd_data[i];
         rem_out[i] = removed_ff[i];
      end
      for (int i = 0; i < CntBits; i++) begin
         cnt_out[i] = occ_ff[i];
      end
   end

   // controller: walks the ram one entry per cycle
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      occ_in       = occ_ff;
      cursor_in    = cursor_ff;
      first_in     = first_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      removed_in   = removed_ff;
      min_in       = min_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = cursor_ff;
      wr_data      = val_ff;
      rd_en        = 1'b0;
      rd_addr      = cursor_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in    = req_data.mode;
               val_in     = req_val;
               pos_in     = req_data.position;
               status_in  = STAT_OK;
               found_in   = 1'b0;
               removed_in = '0;
               state_in   = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            case (mode_ff)
               MODE_INSERT: begin
                  if (occ_ff == CW'(CAPACITY)) begin
                     status_in = STAT_FULL;
                     state_in  = ST_FIN;
                  end else if (occ_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     occ_in   = occ_ff + CW'(1);
                     state_in = ST_FIN;
                  end else begin
                     rd_en     = 1'b1;
                     rd_addr   = AW'(occ_ff - CW'(1));
                     cursor_in = AW'(occ_ff);
                     state_in  = ST_INS_CMP;
                  end
               end
               MODE_REMOVE: begin
                  if (CmpW'(pos_ff) >= CmpW'(occ_ff)) begin
                     status_in = STAT_BAD_POS;
                     state_in  = ST_FIN;
                  end else begin
                     rd_en     = 1'b1;
                     rd_addr   = AW'(pos_ff);
                     cursor_in = AW'(pos_ff);
                     first_in  = 1'b1;
                     state_in  = ST_RM_SHIFT;
                  end
               end
               MODE_CONTAINS: begin
                  if (occ_ff == '0) begin
                     state_in = ST_FIN;
                  end else begin
                     rd_en     = 1'b1;
                     rd_addr   = '0;
                     cursor_in = '0;
                     state_in  = ST_CT_SCAN;
                  end
               end
               MODE_CLEAR: begin
                  occ_in   = '0;
                  state_in = ST_FIN;
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end

         // rd_data holds entry cursor-1; shift it up while it is greater
         ST_INS_CMP: begin
            wr_en   = 1'b1;
            wr_addr = cursor_ff;
            if ($signed(rd_data) > $signed(val_ff)) begin
               wr_data   = rd_data;
               cursor_in = cursor_ff - AW'(1);
               if (cursor_ff == AW'(1)) begin
                  state_in = ST_INS_PUT;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = cursor_ff - AW'(2);
               end
            end else begin
               wr_data  = val_ff;
               occ_in   = occ_ff + CW'(1);
               state_in = ST_FIN;
            end
         end

         // new value lands at the bottom of the table
         ST_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = cursor_ff;
            wr_data  = val_ff;
            occ_in   = occ_ff + CW'(1);
            state_in = ST_FIN;
         end

         // rd_data holds entry cursor; first one is the removed value
         ST_RM_SHIFT: begin
            if (first_ff) begin
               removed_in = rd_data;
               first_in   = 1'b0;
            end else begin
               wr_en   = 1'b1;
               wr_addr = cursor_ff - AW'(1);
               wr_data = rd_data;
            end
            if ((CW'(cursor_ff) + CW'(1)) < occ_ff) begin
               rd_en     = 1'b1;
               rd_addr   = cursor_ff + AW'(1);
               cursor_in = cursor_ff + AW'(1);
            end else begin
               occ_in   = occ_ff - CW'(1);
               state_in = ST_FIN;
            end
         end

         // linear lookup over the valid entries
         ST_CT_SCAN: begin
            if (rd_data == val_ff) begin
               found_in = 1'b1;
            end
            if ((CW'(cursor_ff) + CW'(1)) < occ_ff) begin
               rd_en     = 1'b1;
               rd_addr   = cursor_ff + AW'(1);
               cursor_in = cursor_ff + AW'(1);
            end else begin
               state_in = ST_FIN;
            end
         end

         // fetch smallest and largest entries, or report an empty table
         ST_FIN: begin
            if (occ_ff == '0) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = status_ff;
               rsp_data_in.found         = found_ff;
               rsp_data_in.removed_value = rem_out;
               rsp_data_in.entry_count   = cnt_out;
               rsp_data_in.is_empty      = 1'b1;
               rsp_data_in.min_value     = '0;
               rsp_data_in.max_value     = '0;
               state_in                  = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = ST_FIN_MIN;
            end
         end

         ST_FIN_MIN: begin
            min_in   = rd_data;
            rd_en    = 1'b1;
            rd_addr  = AW'(occ_ff - CW'(1));
            state_in = ST_FIN_MAX;
         end

         ST_FIN_MAX: begin
            rsp_valid_in              = 1'b1;
            rsp_data_in.status        = status_ff;
            rsp_data_in.found         = found_ff;
            rsp_data_in.removed_value = rem_out;
            rsp_data_in.entry_count   = cnt_out;
            rsp_data_in.is_empty      = 1'b0;
            rsp_data_in.min_value     = min_out;
            rsp_data_in.max_value     = max_out;
            state_in                  = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      val_ff      <= val_in;
      pos_ff      <= pos_in;
      cursor_ff   <= cursor_in;
      first_ff    <= first_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      removed_ff  <= removed_in;
      min_ff      <= min_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_value_table_top. A short table of directed
// requests (empty table, extremes, duplicates, full table, bad positions,
// clear) is followed by random bursts that push the table toward full, keep
// it level or push it toward empty. Every accepted request is run through
// a local model of the sorted table, and each response strobe is compared
// field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import svt_pkg::*;

   localparam int DEPTH      = 16;
   localparam int RAND_ITEMS = 1800;
   localparam int TAIL_WAIT  = 40;
   localparam int REQ_BITS   = $bits(svt_req_type);

   localparam logic signed [31:0] VMAX = 32'sh7fffffff;
   localparam logic signed [31:0] VMIN = 32'sh80000000;

   localparam svt_rsp_type RSP_EMPTY = '{STAT_OK, 1'b0, 32'sd0, 5'd0, 1'b1, 32'sd0, 32'sd0};
   localparam svt_rsp_type RSP_NONE  = '0;

   // one directed request, with a hand-written response where it is obvious
   typedef struct packed {
      svt_req_type req;
      logic        typed;
      svt_rsp_type rsp;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   svt_req_type req_data = '0;
   logic        rsp_valid;
   svt_rsp_type rsp_data;

   // model state: sorted entries and their count
   logic signed [31:0] table_vals [DEPTH];
   int                 table_count = 0;

   svt_rsp_type awaited_rsp [$];
   int          fail_count = 0;

   dir_row_type dir_rows [0:25] = '{
      '{'{MODE_CONTAINS, 32'sd0, 4'd0},  1'b1, RSP_EMPTY},
      '{'{MODE_REMOVE,   32'sd0, 4'd0},  1'b1,
        '{STAT_BAD_POS, 1'b0, 32'sd0, 5'd0, 1'b1, 32'sd0, 32'sd0}},
      '{'{MODE_INSERT,   VMAX,   4'd0},  1'b1,
        '{STAT_OK, 1'b0, 32'sd0, 5'd1, 1'b0, VMAX, VMAX}},
      '{'{MODE_INSERT,   VMIN,   4'd0},  1'b1,
        '{STAT_OK, 1'b0, 32'sd0, 5'd2, 1'b0, VMIN, VMAX}},
      '{'{MODE_INSERT,   32'sd0, 4'd0},  1'b0, RSP_NONE},
      '{'{MODE_INSERT,   32'sd0, 4'd0},  1'b0, RSP_NONE},
      '{'{MODE_CONTAINS, 32'sd0, 4'd0},  1'b0, RSP_NONE},
      '{'{MODE_REMOVE,   32'sd0, 4'd15}, 1'b1,
        '{STAT_BAD_POS, 1'b0, 32'sd0, 5'd4, 1'b0, VMIN, VMAX}},
      '{'{MODE_REMOVE,   32'sd0, 4'd1},  1'b0, RSP_NONE},
      '{'{MODE_INSERT,   -32'sd5, 4'd0}, 1'b0, RSP_NONE},
      '{'{MODE_INSERT,   32'sd100, 4'd0}, 1'b0, RSP_NONE},
      '{'{MODE_INSERT,   -32'sd5, 4'd0}, 1'b0, RSP_NONE},
      '{'{MODE_INSERT,   32'sd7, 4'd0},  1'b0, RSP_NONE},
      '{'{MODE_INSERT,   VMIN,   4'd0},  1'b0, RSP_NONE},
      '{'{MODE_INSERT,   VMAX,   4'd0},  1'b0, RSP_NONE},
      '{'{MODE_INSERT,   32'sd1, 4'd0},  1'b0, RSP_NONE},
      '{'{MODE_INSERT,   -32'sd1, 4'd0}, 1'b0, RSP_NONE},
      '{'{MODE_INSERT,   32'sd42, 4'd0}, 1'b0, RSP_NONE},
      '{'{MODE_INSERT,   -32'sd100000, 4'd0}, 1'b0, RSP_NONE},
      '{'{MODE_INSERT,   32'sd3, 4'd0},  1'b0, RSP_NONE},
      '{'{MODE_INSERT,   32'sd99999, 4'd0}, 1'b0, RSP_NONE},
      '{'{MODE_INSERT,   32'sd0, 4'd0},  1'b0, RSP_NONE},
      '{'{MODE_INSERT,   32'sd12, 4'd0}, 1'b1,
        '{STAT_FULL, 1'b0, 32'sd0, 5'd16, 1'b0, VMIN, VMAX}},
      '{'{MODE_CONTAINS, -32'sd7, 4'd0}, 1'b0, RSP_NONE},
      '{'{MODE_REMOVE,   32'sd0, 4'd15}, 1'b0, RSP_NONE},
      '{'{MODE_CLEAR,    32'sd0, 4'd0},  1'b1, RSP_EMPTY}
   };

   sorted_value_table_top DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // model of the sorted table: apply one request, return its response
   task automatic table_apply(input svt_req_type r, output svt_rsp_type e);
      int                 slot;
      logic signed [31:0] v;
      v = r.value;
      e = '0;
      e.status = STAT_OK;
      case (r.mode)
         MODE_INSERT: begin
            if (table_count >= DEPTH) begin
               e.status = STAT_FULL;
            end else begin
               // new value lands after any equal entries
               slot = table_count;
               while (slot > 0 && table_vals[slot-1] > v) begin
                  table_vals[slot] = table_vals[slot-1];
                  slot--;
               end
               table_vals[slot] = v;
               table_count++;
            end
         end
         MODE_REMOVE: begin
            if (int'(r.position) >= table_count) begin
               e.status = STAT_BAD_POS;
            end else begin
               e.removed_value = table_vals[r.position];
               for (int i = int'(r.position) + 1; i < table_count; i++)
                  table_vals[i-1] = table_vals[i];
               table_count--;
            end
         end
         MODE_CONTAINS: begin
            for (int i = 0; i < table_count; i++)
               if (table_vals[i] == v) e.found = 1'b1;
         end
         default: begin
            table_count = 0;
         end
      endcase
      e.entry_count = table_count[4:0];
      e.is_empty    = (table_count == 0);
      if (table_count != 0) begin
         e.min_value = table_vals[0];
         e.max_value = table_vals[table_count-1];
      end
   endtask

   // random value: fresh, already stored, an extreme, or a small one for duplicates
   function automatic logic signed [31:0] pick_value();
      logic signed [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4, 5: v = (table_count > 0) ? table_vals[$urandom_range(0, table_count - 1)]
                                     : $urandom;
         6: begin
            case ($urandom_range(0, 4))
               0: v = VMIN;
               1: v = VMAX;
               2: v = 32'sd0;
               3: v = -32'sd1;
               default: v = 32'sd1;
            endcase
         end
         default: v = $signed($urandom_range(0, 40)) - 32'sd20;
      endcase
      return v;
   endfunction

   // present one request, hold it until taken, then record its prediction
   task automatic send_req(input svt_req_type r, input bit typed, input svt_rsp_type t,
                           input bit no_idle);
      int          gap;
      svt_rsp_type e;
      gap = 0;
      if (!no_idle) begin
         case ($urandom_range(0, 99)) inside
            [0:49]:  gap = 0;
            [50:89]: gap = $urandom_range(1, 3);
            default: gap = $urandom_range(10, 40);
         endcase
      end
      if (gap > 0) begin
         start    <= 1'b0;
         req_data <= svt_req_type'(REQ_BITS'({$urandom, $urandom}));
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      table_apply(r, e);
      awaited_rsp.push_back(typed ? t : e);
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %h, got %h", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   // response checker
   always @(posedge clock) begin : rsp_check
      svt_rsp_type exp_rsp;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_rsp.size() == 0) begin
            $error("response strobe with no request pending");
            fail_count++;
         end else begin
            exp_rsp = awaited_rsp.pop_front();
            check_field("status",        32'(exp_rsp.status),        32'(rsp_data.status));
            check_field("found",         32'(exp_rsp.found),         32'(rsp_data.found));
            check_field("removed_value", exp_rsp.removed_value,      rsp_data.removed_value);
            check_field("entry_count",   32'(exp_rsp.entry_count),   32'(rsp_data.entry_count));
            check_field("is_empty",      32'(exp_rsp.is_empty),      32'(rsp_data.is_empty));
            check_field("min_value",     exp_rsp.min_value,          rsp_data.min_value);
            check_field("max_value",     exp_rsp.max_value,          rsp_data.max_value);
         end
      end
   end

   // stimulus
   initial begin : stimulus
      svt_req_type r;
      int          issued;
      int          burst_len;
      int          ins_pct;
      int          rem_pct;
      int          roll;
      bit          no_idle;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (dir_rows[i])
         send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp, 1'b0);

      // random bursts, each leaning toward growth, balance or drain
      issued = 0;
      while (issued < RAND_ITEMS) begin
         burst_len = $urandom_range(10, 60);
         no_idle   = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 2))
            0: begin ins_pct = 65; rem_pct = 15; end
            1: begin ins_pct = 35; rem_pct = 35; end
            default: begin ins_pct = 15; rem_pct = 60; end
         endcase
         for (int k = 0; k < burst_len; k++) begin
            roll = $urandom_range(0, 99);
            r.value    = pick_value();
            r.position = 4'($urandom_range(0, 15));
            if (roll < 2) begin
               r.mode = MODE_CLEAR;
            end else if (roll < 2 + ins_pct) begin
               r.mode = MODE_INSERT;
            end else if (roll < 2 + ins_pct + rem_pct) begin
               r.mode = MODE_REMOVE;
               if (table_count > 0 && $urandom_range(0, 1) == 1)
                  r.position = 4'($urandom_range(0, table_count - 1));
            end else begin
               r.mode = MODE_CONTAINS;
            end
            send_req(r, 1'b0, RSP_NONE, no_idle);
            issued++;
         end
      end

      start <= 1'b0;

      // drain, then allow for any stray response
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
